// ----- hw/rtl/lpld_pkg.sv -----
// Shared types and constants for the length-prefixed list deframer.
`default_nettype none

package lpld_pkg;

    localparam logic [7:0] SHORT_LIMIT   = 8'd248;
    localparam logic [7:0] LONG_BASE     = 8'd247;
    localparam logic [3:0] MAX_LEN_BYTES = 4'd8;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam int LEN_W = 64;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_LAST    = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_OK      = 3'd4,
        KIND_TRUNC   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [15:0] parts_done;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/length_prefixed_list_deframer.sv -----
// Top level of the length-prefixed list deframer.
`default_nettype none

// Decodes a byte stream holding a list of length-prefixed parts. Every
// request on the input gives exactly one result request that classifies
// it (header, payload, last payload, empty part, list complete, truncated)
// together with a saturating count of the parts completed in the current
// list. A request is taken in every cycle while the skid register is empty:
// the per-byte work is one 64-bit length update and zero test between the
// decoder state and the result register, and a skid register behind the
// result register lets the input take one more request while the output is
// stalled. Each result is registered before it is offered.
module length_prefixed_list_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] mode (1 = end of list)

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // [7:0] payload, [23:8] parts_done
    output      logic [2:0]  m_tuser    // [2:0] kind
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    phase_t                        phase_reg,  phase_next;
    logic [3:0]                    left_reg,   left_next;
    logic [2:0]                    shift_reg,  shift_next;
    logic [lpld_pkg::LEN_W-1:0]    length_reg, length_next;
    logic [15:0]                   count_reg,  count_next;

    lpld_pkg::result_t             res;
    lpld_pkg::result_t             out_reg;
    lpld_pkg::result_t             skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;

    logic                          push;
    logic [lpld_pkg::LEN_W-1:0]    len_ins;
    logic [lpld_pkg::LEN_W-1:0]    len_dec;
    logic [3:0]                    left_dec;
    logic [7:0]                    long_count;
    logic [15:0]                   count_inc;

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.parts_done, out_reg.payload};
    assign m_tuser  = out_reg.kind;

    // Length bytes land in distinct byte lanes of a cleared register, so an
    // OR does the little-endian accumulation.
    assign len_ins    = length_reg
                        | ({{(lpld_pkg::LEN_W-8){1'b0}}, s_tdata} << {shift_reg, 3'b000});
    assign len_dec    = length_reg - {{(lpld_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign left_dec   = left_reg - 4'd1;
    assign long_count = s_tdata - lpld_pkg::LONG_BASE;
    assign count_inc  = (count_reg == lpld_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        length_next = length_reg;
        count_next  = count_reg;
        res.kind    = lpld_pkg::KIND_HEADER;
        res.payload = 8'd0;

        if (s_tuser)
        begin
            if (phase_reg == PH_LEN || phase_reg == PH_PAY)
                res.kind = lpld_pkg::KIND_TRUNC;
            else
                res.kind = lpld_pkg::KIND_OK;
            phase_next  = PH_IDLE;
            left_next   = 4'd0;
            shift_next  = 3'd0;
            length_next = '0;
            count_next  = 16'd0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    length_next = len_ins;
                    shift_next  = shift_reg + 3'd1;
                    left_next   = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        if (len_ins == '0)
                        begin
                            res.kind    = lpld_pkg::KIND_EMPTY;
                            count_next  = count_inc;
                            phase_next  = PH_IDLE;
                            left_next   = 4'd0;
                            shift_next  = 3'd0;
                            length_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAY;
                            shift_next = 3'd0;
                        end
                    end
                end
                PH_PAY:
                begin
                    res.payload = s_tdata;
                    length_next = len_dec;
                    if (len_dec == '0)
                    begin
                        res.kind   = lpld_pkg::KIND_LAST;
                        count_next = count_inc;
                        phase_next = PH_IDLE;
                        left_next  = 4'd0;
                        shift_next = 3'd0;
                    end
                    else
                    begin
                        res.kind = lpld_pkg::KIND_PAYLOAD;
                    end
                end
                default:
                begin
                    // Idle, and the unused phase code behaves the same way.
                    phase_next  = PH_IDLE;
                    left_next   = 4'd0;
                    shift_next  = 3'd0;
                    length_next = '0;
                    if (s_tdata < lpld_pkg::SHORT_LIMIT)
                    begin
                        if (s_tdata == 8'd0)
                        begin
                            res.kind   = lpld_pkg::KIND_EMPTY;
                            count_next = count_inc;
                        end
                        else
                        begin
                            length_next = {{(lpld_pkg::LEN_W-8){1'b0}}, s_tdata};
                            phase_next  = PH_PAY;
                        end
                    end
                    else
                    begin
                        if (long_count[3:0] > lpld_pkg::MAX_LEN_BYTES)
                            left_next = lpld_pkg::MAX_LEN_BYTES;
                        else
                            left_next = long_count[3:0];
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end

        // An end marker reports the count of the list it closes.
        res.parts_done = s_tuser ? count_reg : count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            left_reg       <= 4'd0;
            shift_reg      <= 3'd0;
            length_reg     <= '0;
            count_reg      <= 16'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                shift_reg  <= shift_next;
                length_reg <= length_next;
                count_reg  <= count_next;
            end

            if (!out_valid_reg || m_tready)
            begin
                // Output register is free this cycle; the skid entry is older.
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_length_prefixed_list_deframer.sv -----
// Self-checking testbench for the length-prefixed list deframer.
`default_nettype none

module tb_length_prefixed_list_deframer;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;
    localparam int   RANDOM_ITEMS = 450;

    typedef enum logic [1:0] {
        PARSE_IDLE = 2'd0,
        PARSE_LEN  = 2'd1,
        PARSE_PAY  = 2'd2
    } parse_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    // Expected results, oldest first.
    lpld_pkg::result_t pending_results[$];
    int unsigned items_sent = 0;
    int unsigned fail_cnt   = 0;
    bit          quiet      = 1'b0;

    // Shadow copy of the decoder state.
    parse_t      parse_st  = PARSE_IDLE;
    logic [3:0]  len_left  = '0;
    logic [2:0]  shift_pos = '0;
    logic [63:0] len_rem   = '0;
    logic [15:0] part_cnt  = '0;

    length_prefixed_list_deframer u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function void clear_parse();
        parse_st  = PARSE_IDLE;
        len_left  = '0;
        shift_pos = '0;
        len_rem   = '0;
    endfunction

    function void count_part();
        if (part_cnt != lpld_pkg::COUNT_MAX)
            part_cnt = part_cnt + 16'd1;
    endfunction

    // Advances the shadow decoder by one request and queues the result it gives.
    function void predict_result(input logic end_mark, input logic [7:0] b);
        lpld_pkg::result_t r;
        r.kind       = lpld_pkg::KIND_HEADER;
        r.payload    = 8'd0;
        r.parts_done = '0;
        if (end_mark)
        begin
            if (parse_st == PARSE_LEN || parse_st == PARSE_PAY)
                r.kind = lpld_pkg::KIND_TRUNC;
            else
                r.kind = lpld_pkg::KIND_OK;
            r.parts_done = part_cnt;
            clear_parse();
            part_cnt = '0;
        end
        else
        begin
            case (parse_st)
                PARSE_LEN:
                begin
                    len_rem   = len_rem + (64'(b) << {shift_pos, 3'b000});
                    shift_pos = shift_pos + 3'd1;
                    len_left  = len_left - 4'd1;
                    if (len_left == 4'd0)
                    begin
                        if (len_rem == 64'd0)
                        begin
                            r.kind = lpld_pkg::KIND_EMPTY;
                            count_part();
                            clear_parse();
                        end
                        else
                        begin
                            parse_st  = PARSE_PAY;
                            shift_pos = '0;
                        end
                    end
                end
                PARSE_PAY:
                begin
                    r.payload = b;
                    len_rem   = len_rem - 64'd1;
                    if (len_rem == 64'd0)
                    begin
                        r.kind = lpld_pkg::KIND_LAST;
                        count_part();
                        clear_parse();
                    end
                    else
                    begin
                        r.kind = lpld_pkg::KIND_PAYLOAD;
                    end
                end
                default:
                begin
                    clear_parse();
                    if (b < lpld_pkg::SHORT_LIMIT)
                    begin
                        if (b == 8'd0)
                        begin
                            r.kind = lpld_pkg::KIND_EMPTY;
                            count_part();
                        end
                        else
                        begin
                            len_rem  = 64'(b);
                            parse_st = PARSE_PAY;
                        end
                    end
                    else
                    begin
                        len_left = 4'(b - lpld_pkg::LONG_BASE);
                        if (len_left > lpld_pkg::MAX_LEN_BYTES)
                            len_left = lpld_pkg::MAX_LEN_BYTES;
                        parse_st = PARSE_LEN;
                    end
                end
            endcase
            r.parts_done = part_cnt;
        end
        pending_results = {pending_results, r};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input logic end_mark, input logic [7:0] b);
        begin
            while (!quiet && $urandom_range(99) < 8)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                s_tuser  <= 1'($urandom);
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            s_tuser  <= end_mark;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_result(end_mark, b);
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
        end
    endtask

    // One part with random content; sometimes cut short by an end marker.
    task automatic send_random_part(output bit cut);
        logic [7:0]  part_q[$];
        logic [63:0] plen;
        logic [7:0]  lb;
        int unsigned nlb;
        int unsigned npay;
        int unsigned stop_at;
        bit          huge;
        begin
            part_q = {};
            plen   = '0;
            huge   = 1'b0;
            if ($urandom_range(99) < 55)
            begin
                plen = 64'($urandom_range(12));
                part_q = {part_q, plen[7:0]};
            end
            else
            begin
                nlb  = $urandom_range(8, 1);
                // A huge length can never finish here, so such parts always end truncated.
                huge = (nlb > 1) && ($urandom_range(9) == 0);
                part_q = {part_q, 8'(lpld_pkg::LONG_BASE + nlb)};
                for (int i = 0; i < nlb; i++)
                begin
                    if (huge)
                        lb = (i == nlb - 1) ? 8'($urandom_range(255, 1)) : 8'($urandom);
                    else
                        lb = (i == 0) ? 8'($urandom_range(12)) : 8'd0;
                    plen = plen | (64'(lb) << (8 * i));
                    part_q = {part_q, lb};
                end
            end
            npay = huge ? $urandom_range(5) : int'(plen);
            for (int i = 0; i < npay; i++)
                part_q = {part_q, 8'($urandom)};

            cut = huge || (part_q.size() > 1 && $urandom_range(99) < 8);
            if (huge)
                stop_at = $urandom_range(part_q.size(), 1);
            else if (cut)
                stop_at = $urandom_range(part_q.size() - 1, 1);
            else
                stop_at = part_q.size();

            for (int i = 0; i < stop_at; i++)
                send_req(MODE_DATA, part_q[i]);
            if (cut)
                send_req(MODE_END, 8'($urandom));
        end
    endtask

    task automatic test_short_parts();
        begin
            send_req(MODE_DATA, 8'd0);
            send_req(MODE_DATA, 8'd2);
            send_req(MODE_DATA, 8'hFF);
            send_req(MODE_DATA, 8'h00);
            send_req(MODE_END, 8'hFF);
            // End marker straight after another one closes an empty list.
            send_req(MODE_END, 8'h00);
        end
    endtask

    task automatic test_long_form();
        begin
            send_req(MODE_DATA, 8'd248);
            send_req(MODE_DATA, 8'h00);
            send_req(MODE_DATA, 8'd249);
            send_req(MODE_DATA, 8'h01);
            send_req(MODE_DATA, 8'h00);
            send_req(MODE_DATA, 8'h7E);
            send_req(MODE_END, 8'h5A);
        end
    endtask

    task automatic test_truncation();
        begin
            send_req(MODE_DATA, 8'd3);
            send_req(MODE_DATA, 8'h11);
            send_req(MODE_END, 8'h00);
            send_req(MODE_DATA, 8'd250);
            send_req(MODE_DATA, 8'h05);
            send_req(MODE_END, 8'h80);
        end
    endtask

    task automatic test_random_lists();
        int unsigned stop_count;
        int unsigned lst;
        int unsigned nparts;
        bit          cut;
        begin
            stop_count = items_sent + RANDOM_ITEMS;
            lst = 0;
            while (items_sent < stop_count)
            begin
                quiet = (lst >= 15 && lst < 30);
                if (lst == 10)
                    wait_for_drain();
                if (lst == 3)
                begin
                    // Longest part that the short form can describe.
                    send_req(MODE_DATA, lpld_pkg::LONG_BASE);
                    for (int i = 0; i < lpld_pkg::LONG_BASE; i++)
                        send_req(MODE_DATA, 8'($urandom));
                end
                nparts = $urandom_range(6);
                cut = 1'b0;
                for (int p = 0; p < nparts && !cut; p++)
                    send_random_part(cut);
                if (!cut)
                    send_req(MODE_END, 8'($urandom));
                if ($urandom_range(9) == 0)
                    send_req(MODE_END, 8'($urandom));
                lst++;
            end
            quiet = 1'b0;
        end
    endtask

    always @(negedge clk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);

    always @(posedge clk)
    begin : check_results
        lpld_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    fail_cnt++;
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, m_tuser);
                end
                if (m_tdata[7:0] !== want.payload)
                begin
                    fail_cnt++;
                    $display("%0t: payload mismatch: expected %h, actual %h",
                             $time, want.payload, m_tdata[7:0]);
                end
                if (m_tdata[23:8] !== want.parts_done)
                begin
                    fail_cnt++;
                    $display("%0t: parts_done mismatch: expected %0d, actual %0d",
                             $time, want.parts_done, m_tdata[23:8]);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_parts();
        test_long_form();
        test_truncation();
        test_random_lists();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
